// ===== rtl/cvkt_pkg.sv =====
// package: shared types and constants for the constant-velocity tracker
package cvkt_pkg;

    localparam logic [1:0] OP_INIT    = 2'd0;
    localparam logic [1:0] OP_PREDICT = 2'd1;
    localparam logic [1:0] OP_UPDATE  = 2'd2;

    localparam logic CFG_MEAS_NOISE  = 1'b0;
    localparam logic CFG_INITIAL_COV = 1'b1;

    // room for a 32-bit magnitude shifted by up to 24 fraction bits
    localparam int DIV_QW = 56;

    typedef struct packed {
        logic               start;
        logic               negative;
        logic [DIV_QW-1:0]  dividend;
        logic [31:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [33:0] quotient;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic is_clip(input logic signed [65:0] v);
        return (v > 66'sd2147483647) || (v < -66'sd2147483648);
    endfunction

endpackage

// ===== rtl/cvkt_divider.sv =====
// module: restoring divider, one quotient bit per cycle, rounds half away from zero
module cvkt_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  cvkt_pkg::div_req_t req,
    output cvkt_pkg::div_rsp_t rsp
);
    import cvkt_pkg::*;

    localparam int CW = $clog2(DIV_QW + 2);

    logic [DIV_QW:0]   num_reg, num_next;
    logic [DIV_QW:0]   quo_reg, quo_next;
    logic [33:0]       rem_reg, rem_next;
    logic [32:0]       den_reg, den_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    logic [34:0]       trial;
    logic [DIV_QW:0]   qround;

    // quotient of (2*mag + d) / (2*d)
    always_comb begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        trial     = {rem_reg, num_reg[DIV_QW]};
        if (req.start) begin
            num_next  = {req.dividend, 1'b0} + {{(DIV_QW-31){1'b0}}, req.divisor};
            den_next  = {req.divisor, 1'b0};
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CW'(DIV_QW + 1);
            busy_next = 1'b1;
            neg_next  = req.negative;
        end else if (busy_reg) begin
            if (trial >= {2'b0, den_reg}) begin
                rem_next = 34'(trial - {2'b0, den_reg});
                quo_next = {quo_reg[DIV_QW-1:0], 1'b1};
            end else begin
                rem_next = trial[33:0];
                quo_next = {quo_reg[DIV_QW-1:0], 1'b0};
            end
            num_next = {num_reg[DIV_QW-1:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // saturate magnitude to 33 bits so sat32 downstream clips correctly
    assign qround = (|quo_reg[DIV_QW:33]) ? {{(DIV_QW-32){1'b0}}, 33'h100000000} : quo_reg;
    assign rsp.done = done_reg;
    assign rsp.quotient = neg_reg ? -$signed({1'b0, qround[32:0]})
                                  : $signed({1'b0, qround[32:0]});

endmodule

// ===== rtl/constant_velocity_kalman_tracker.sv =====
// module: top level of the constant-velocity Kalman tracker
// One word is handled at a time: init, an unused op and any op before init go straight to
// the output step; predict and update each step through the three axes (an axis whose
// innovation variance is not positive is left unchanged by update). Time is set by one
// shared 32x32 multiplier used at most once per sequencer step and one bit-serial divider that
// yields one quotient bit per cycle. The result sits in its own output register, so the
// next word is taken while it waits; s_tready is high only in the idle state.
module constant_velocity_kalman_tracker #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [30:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op, meas_x, meas_y, meas_z, step_time
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    output logic [191:0] m_tdata,
    // tracking, saturated
    output logic [1:0]   m_tuser
);
    import cvkt_pkg::*;

    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

    localparam logic [4:0] S_IDLE = 5'd0,  S_P_D2  = 5'd1,  S_P_POS = 5'd2,
                           S_P_PV = 5'd3,  S_P_VV  = 5'd4,  S_P_PVN = 5'd5,
                           S_U_CHK = 5'd6, S_U_KPW = 5'd8,
                           S_U_KVW = 5'd9, S_U_POS = 5'd10, S_U_VEL = 5'd11,
                           S_U_PP = 5'd12, S_U_PV  = 5'd13, S_U_VV  = 5'd14,
                           S_OUT  = 5'd15;

    logic [4:0]          st_reg, st_next;
    logic [1:0]          ax_reg, ax_next;
    logic signed [31:0]  x_reg [6];
    logic signed [31:0]  x_next [6];
    logic signed [31:0]  p_reg [9];
    logic signed [31:0]  p_next [9];
    logic                init_reg, init_next;
    logic                clip_reg, clip_next;
    logic                outv_reg, outv_next;
    logic [191:0]        mdata_reg, mdata_next;
    logic [1:0]          muser_reg, muser_next;
    logic [30:0]         rvar_reg, icov_reg;
    logic [119:0]        in_reg, in_next;
    logic signed [31:0]  d2_reg, d2_next;
    logic signed [31:0]  kp_reg, kp_next, kv_reg, kv_next, e_reg, e_next;
    logic signed [31:0]  t1_reg, t1_next;
    logic signed [31:0]  ma, mb;
    logic signed [63:0]  prod;
    logic signed [65:0]  rp, acc;
    logic signed [32:0]  dt;
    logic [3:0]          b;
    logic [2:0]          xi, vi;
    logic signed [32:0]  sv;
    div_req_t            dreq;
    div_rsp_t            drsp;
    logic signed [31:0]  meas_a;

    cvkt_divider u_div (.aclk, .aresetn, .req(dreq), .rsp(drsp));

    assign dt = $signed({13'b0, in_reg[117:98]});
    assign b  = {ax_reg, 1'b0} + {2'b0, ax_reg};
    assign xi = {1'b0, ax_reg};
    assign vi = xi + 3'd3;
    assign sv = $signed({p_reg[b][31], p_reg[b]}) + $signed({2'b0, rvar_reg});
    assign meas_a = (ax_reg == 2'd0) ? $signed(in_reg[33:2])
                  : (ax_reg == 2'd1) ? $signed(in_reg[65:34]) : $signed(in_reg[97:66]);

    // one shared multiplier, operands chosen per step
    always_comb begin
        ma = 32'sd0;
        mb = 32'sd0;
        unique case (st_reg)
            S_P_D2:  begin ma = dt[31:0]; mb = dt[31:0]; end
            S_P_POS: begin ma = dt[31:0]; mb = x_reg[vi]; end
            S_P_PV:  begin ma = dt[31:0]; mb = p_reg[b + 4'd1]; end
            S_P_VV:  begin ma = d2_reg; mb = p_reg[b + 4'd2]; end
            S_P_PVN: begin ma = dt[31:0]; mb = p_reg[b + 4'd2]; end
            S_U_POS: begin ma = kp_reg; mb = e_reg; end
            S_U_VEL: begin ma = kv_reg; mb = e_reg; end
            S_U_PP:  begin ma = kp_reg; mb = p_reg[b]; end
            S_U_PV:  begin ma = kp_reg; mb = p_reg[b + 4'd1]; end
            S_U_VV:  begin ma = kv_reg; mb = p_reg[b + 4'd1]; end
            default: begin ma = 32'sd0; mb = 32'sd0; end
        endcase
    end

    assign prod = ma * mb;
    assign rp   = (66'(prod) + HALF) >>> FRAC_BITS;

    always_comb begin
        st_next    = st_reg;
        ax_next    = ax_reg;
        x_next     = x_reg;
        p_next     = p_reg;
        init_next  = init_reg;
        clip_next  = clip_reg;
        outv_next  = outv_reg;
        mdata_next = mdata_reg;
        muser_next = muser_reg;
        in_next    = in_reg;
        d2_next    = d2_reg;
        kp_next    = kp_reg;
        kv_next    = kv_reg;
        e_next     = e_reg;
        t1_next    = t1_reg;
        dreq       = '0;
        acc        = '0;
        if (outv_reg && m_tready) begin
            outv_next = 1'b0;
        end
        unique case (st_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    in_next   = s_tdata;
                    clip_next = 1'b0;
                    ax_next   = 2'd0;
                    if (s_tdata[1:0] == OP_INIT) begin
                        x_next[0] = $signed(s_tdata[33:2]);
                        x_next[1] = $signed(s_tdata[65:34]);
                        x_next[2] = $signed(s_tdata[97:66]);
                        for (int i = 3; i < 6; i++) x_next[i] = '0;
                        for (int a = 0; a < 3; a++) begin
                            p_next[3*a]   = $signed({1'b0, icov_reg});
                            p_next[3*a+1] = '0;
                            p_next[3*a+2] = $signed({1'b0, icov_reg});
                        end
                        init_next = 1'b1;
                        st_next   = S_OUT;
                    end else if (s_tdata[1:0] == OP_PREDICT && init_reg) begin
                        st_next = S_P_D2;
                    end else if (s_tdata[1:0] == OP_UPDATE && init_reg) begin
                        st_next = S_U_CHK;
                    end else begin
                        st_next = S_OUT;
                    end
                end
            end
            S_P_D2: begin
                d2_next   = sat32(rp);
                clip_next = clip_reg | is_clip(rp);
                st_next   = S_P_POS;
            end
            S_P_POS: begin
                acc = 66'(x_reg[xi]) + rp;
                x_next[xi] = sat32(acc);
                clip_next = clip_reg | is_clip(acc);
                st_next = S_P_PV;
            end
            S_P_PV: begin
                // pp + 2*round(d*pv) + q, held in t1 (low word) and e (high word) for the next step
                acc = 66'(p_reg[b]) + (rp <<< 1) + ((66'(d2_reg) + 66'sd1) >>> 1);
                t1_next = acc[31:0];
                d2_next = d2_reg;
                e_next  = acc[63:32];
                st_next = S_P_VV;
            end
            S_P_VV: begin
                acc = $signed({e_reg, t1_reg}) + rp;
                p_next[b] = sat32(acc);
                clip_next = clip_reg | is_clip(acc);
                st_next = S_P_PVN;
            end
            S_P_PVN: begin
                acc = 66'(p_reg[b + 4'd1]) + rp;
                p_next[b + 4'd1] = sat32(acc);
                clip_next = clip_reg | is_clip(acc);
                acc = 66'(p_reg[b + 4'd2]) + 66'(dt);
                p_next[b + 4'd2] = sat32(acc);
                clip_next = clip_next | is_clip(acc);
                if (ax_reg == 2'd2) begin
                    st_next = S_OUT;
                end else begin
                    ax_next = ax_reg + 2'd1;
                    st_next = S_P_POS;
                end
            end
            S_U_CHK: begin
                if (sv <= 33'sd0) begin
                    if (ax_reg == 2'd2) st_next = S_OUT;
                    else ax_next = ax_reg + 2'd1;
                end else begin
                    dreq.start    = 1'b1;
                    dreq.negative = p_reg[b][31];
                    dreq.dividend = DIV_QW'(p_reg[b][31] ? 33'(-(33'(p_reg[b])))
                                                          : 33'(p_reg[b])) << FRAC_BITS;
                    dreq.divisor  = sv[31:0];
                    st_next = S_U_KPW;
                end
            end
            S_U_KPW: begin
                if (drsp.done) begin
                    kp_next   = sat32(66'(drsp.quotient));
                    clip_next = clip_reg | is_clip(66'(drsp.quotient));
                    dreq.start    = 1'b1;
                    dreq.negative = p_reg[b + 4'd1][31];
                    dreq.dividend = DIV_QW'(p_reg[b + 4'd1][31]
                                    ? 33'(-(33'(p_reg[b + 4'd1]))) : 33'(p_reg[b + 4'd1]))
                                    << FRAC_BITS;
                    dreq.divisor  = sv[31:0];
                    st_next = S_U_KVW;
                end
            end
            S_U_KVW: begin
                if (drsp.done) begin
                    kv_next   = sat32(66'(drsp.quotient));
                    acc       = 66'(meas_a) - 66'(x_reg[xi]);
                    e_next    = sat32(acc);
                    clip_next = clip_reg | is_clip(66'(drsp.quotient)) | is_clip(acc);
                    st_next   = S_U_POS;
                end
            end
            S_U_POS: begin
                acc = 66'(x_reg[xi]) + rp;
                x_next[xi] = sat32(acc);
                clip_next = clip_reg | is_clip(acc);
                st_next = S_U_VEL;
            end
            S_U_VEL: begin
                acc = 66'(x_reg[vi]) + rp;
                x_next[vi] = sat32(acc);
                clip_next = clip_reg | is_clip(acc);
                st_next = S_U_PP;
            end
            S_U_PP: begin
                t1_next = p_reg[b + 4'd1];
                acc = 66'(p_reg[b]) - rp;
                p_next[b] = sat32(acc);
                clip_next = clip_reg | is_clip(acc);
                st_next = S_U_VV;
            end
            S_U_VV: begin
                // old pv still in place; vv uses it before pv is written
                acc = 66'(p_reg[b + 4'd2]) - rp;
                p_next[b + 4'd2] = sat32(acc);
                clip_next = clip_reg | is_clip(acc);
                st_next = S_U_PV;
            end
            S_U_PV: begin
                acc = 66'(t1_reg) - rp;
                p_next[b + 4'd1] = sat32(acc);
                clip_next = clip_reg | is_clip(acc);
                if (ax_reg == 2'd2) begin
                    st_next = S_OUT;
                end else begin
                    ax_next = ax_reg + 2'd1;
                    st_next = S_U_CHK;
                end
            end
            S_OUT: begin
                // wait here while the previous word still sits on the m_ side
                if (!outv_reg || m_tready) begin
                    outv_next  = 1'b1;
                    mdata_next = {x_reg[5], x_reg[4], x_reg[3], x_reg[2], x_reg[1], x_reg[0]};
                    muser_next = {clip_reg, init_reg};
                    st_next    = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    assign s_tready = (st_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            ax_reg   <= 2'd0;
            init_reg <= 1'b0;
            clip_reg <= 1'b0;
            outv_reg <= 1'b0;
            rvar_reg <= 31'(64'sd1 <<< (FRAC_BITS - 2));
            icov_reg <= 31'(64'sd100 <<< FRAC_BITS);
            for (int i = 0; i < 6; i++) x_reg[i] <= '0;
            for (int a = 0; a < 3; a++) begin
                p_reg[3*a]   <= 32'(64'sd100 <<< FRAC_BITS);
                p_reg[3*a+1] <= '0;
                p_reg[3*a+2] <= 32'(64'sd100 <<< FRAC_BITS);
            end
        end else begin
            st_reg   <= st_next;
            ax_reg   <= ax_next;
            init_reg <= init_next;
            clip_reg <= clip_next;
            outv_reg <= outv_next;
            x_reg    <= x_next;
            p_reg    <= p_next;
            if (cfg_we) begin
                if (cfg_index[0] == CFG_MEAS_NOISE) rvar_reg <= cfg_data;
                else icov_reg <= cfg_data;
            end
        end
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
        in_reg <= in_next;
        d2_reg <= d2_next;
        kp_reg <= kp_next;
        kv_reg <= kv_next;
        e_reg  <= e_next;
        t1_reg <= t1_next;
    end

    assign m_tvalid = outv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (st_reg == S_IDLE)) else $error("ready outside idle");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while waiting");
    a_track_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(init_reg) |-> init_reg) else $error("tracking dropped");
endmodule
